[rtl/core/jis7ld_pkg.sv]
// ----------------------------------------------------------------------------
// jis7ld_pkg: shared types and constants of the JIS7 line decoder
// Holds the result record, the symbol lookup and the pair bit-phase table.
// ----------------------------------------------------------------------------
package jis7ld_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KindData   = 2'd0;
  localparam logic [1:0] KindAccept = 2'd1;
  localparam logic [1:0] KindReject = 2'd2;

  // Line limit after reset, and the number of header characters.
  localparam logic [7:0] ResetLimit = 8'd78;
  localparam logic [7:0] HeadChars  = 8'd4;

  // Radix of one symbol pair.
  localparam logic [13:0] Radix = 14'd91;

  // Most results one input transfer can cause.
  localparam int unsigned MaxResults = 3;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       last_result;
  } res_t;

  // All results of one input transfer, in order, with their number.
  typedef struct packed {
    logic [1:0]                 num;
    res_t [MaxResults-1:0]      res;
  } bundle_t;

  // Reverse alphabet: bit 7 flags an invalid code, bits 6:0 hold the symbol.
  // The alphabet is 0x21..0x7e without 0x23, 0x2e and 0x60.
  function automatic logic [7:0] sym_lookup(input logic [7:0] c);
    logic [7:0] v;
    logic       bad;
    bad = (c < 8'h21) || (c > 8'h7e) || (c == 8'h23) || (c == 8'h2e) || (c == 8'h60);
    v = c - 8'h21 - {7'd0, (c > 8'h23)} - {7'd0, (c > 8'h2e)} - {7'd0, (c > 8'h60)};
    return {bad, v[6:0]};
  endfunction

  // Bit phase of the held byte for each pair index.
  function automatic logic [2:0] phase_lookup(input logic [2:0] p);
    logic [2:0] j;
    unique case (p)
      3'd0: j = 3'd0;
      3'd1: j = 3'd3;
      3'd2: j = 3'd6;
      3'd3: j = 3'd1;
      3'd4: j = 3'd4;
      3'd5: j = 3'd7;
      3'd6: j = 3'd2;
      default: j = 3'd5;
    endcase
    return j;
  endfunction

endpackage

[rtl/core/jis7ld_core.sv]
// ----------------------------------------------------------------------------
// jis7ld_core: per-line decode state and result generation
// Holds the line state and forms, in one pass, all results of a character.
// ----------------------------------------------------------------------------
module jis7ld_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           char_code_i,
  input  logic                 line_end_i,
  input  logic [7:0]           line_limit_i,
  output jis7ld_pkg::bundle_t  bundle_o
);

  logic [7:0]  char_index_q, char_index_d;
  logic [6:0]  saved_symbol_q, saved_symbol_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic [2:0]  pair_phase_q, pair_phase_d;
  logic [7:0]  bytes_emitted_q, bytes_emitted_d;
  logic        line_bad_q, line_bad_d;

  logic [7:0]  lookup;
  logic [7:0]  sym8;
  logic        in_range;
  logic        bad_n;
  logic [7:0]  idx_inc;
  logic [13:0] pair_val;
  logic [2:0]  j;
  logic [21:0] shl;
  logic [13:0] shr;
  logic [1:0]  nbytes;
  logic [7:0]  b0, b1;
  logic [8:0]  emit_sum;
  logic [7:0]  cnt;
  logic        reject;
  jis7ld_pkg::bundle_t bnd;

  // Symbol decode and the pair value with its shifted forms.
  always_comb begin
    lookup   = jis7ld_pkg::sym_lookup(char_code_i);
    sym8     = {1'b0, lookup[6:0]};
    in_range = char_index_q < line_limit_i;
    bad_n    = line_bad_q | (in_range & lookup[7]);
    idx_inc  = (char_index_q == 8'hff) ? char_index_q : char_index_q + 8'd1;
    pair_val = {7'd0, saved_symbol_q} * jis7ld_pkg::Radix + {7'd0, lookup[6:0]};
    j        = jis7ld_pkg::phase_lookup(pair_phase_q);
    shl      = {8'd0, pair_val} << (4'd8 - {1'b0, j});
    shr      = pair_val >> j;
  end

  // Next line state and the data bytes of this character.
  always_comb begin
    saved_symbol_d = saved_symbol_q;
    held_byte_d    = held_byte_q;
    pair_phase_d   = pair_phase_q;
    nbytes         = 2'd0;
    b0             = 8'd0;
    b1             = 8'd0;
    if (in_range && !bad_n) begin
      case (char_index_q)
        8'd0: begin
          held_byte_d = sym8;
        end
        8'd1: begin
          nbytes      = 2'd1;
          b0          = (sym8 << 6) | held_byte_q;
          held_byte_d = sym8 >> 2;
        end
        8'd2: begin
          nbytes      = 2'd1;
          b0          = (sym8 << 4) | held_byte_q;
          held_byte_d = sym8 >> 4;
        end
        8'd3: begin
          held_byte_d = (sym8 << 2) | held_byte_q;
        end
        default: begin
          if (!char_index_q[0]) begin
            // First symbol of a pair.
            saved_symbol_d = lookup[6:0];
          end else begin
            // Second symbol: splice the pair value into the held byte.
            b0 = held_byte_q | shl[7:0];
            if (j < 3'd5) begin
              nbytes      = 2'd2;
              b1          = shr[7:0];
              held_byte_d = {2'd0, shr[13:8]};
            end else begin
              nbytes      = 2'd1;
              held_byte_d = shr[7:0];
            end
            pair_phase_d = pair_phase_q + 3'd1;
          end
        end
      endcase
    end
  end

  // Byte count, line verdict and the ordered result list.
  always_comb begin
    emit_sum = {1'b0, bytes_emitted_q} + {7'd0, nbytes};
    bytes_emitted_d = emit_sum[8] ? 8'hff : emit_sum[7:0];
    cnt    = (idx_inc < line_limit_i) ? idx_inc : line_limit_i;
    reject = bad_n || (cnt < jis7ld_pkg::HeadChars) || cnt[0];

    bnd = '0;
    if (nbytes != 2'd0) begin
      bnd.res[0].kind      = jis7ld_pkg::KindData;
      bnd.res[0].data_byte = b0;
    end
    if (nbytes == 2'd2) begin
      bnd.res[1].kind      = jis7ld_pkg::KindData;
      bnd.res[1].data_byte = b1;
    end
    if (line_end_i) begin
      if (reject) begin
        bnd.res[nbytes].kind = jis7ld_pkg::KindReject;
      end else begin
        bnd.res[nbytes].kind       = jis7ld_pkg::KindAccept;
        bnd.res[nbytes].byte_count = bytes_emitted_d;
      end
    end
    bnd.num = nbytes + {1'b0, line_end_i};
    if (bnd.num != 2'd0) begin
      bnd.res[bnd.num - 2'd1].last_result = 1'b1;
    end
    bundle_o = bnd;
  end

  // Line state registers; a line end clears them for the next line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_index_q    <= '0;
      saved_symbol_q  <= '0;
      held_byte_q     <= '0;
      pair_phase_q    <= '0;
      bytes_emitted_q <= '0;
      line_bad_q      <= 1'b0;
    end else if (accept_i) begin
      if (line_end_i) begin
        char_index_q    <= '0;
        saved_symbol_q  <= '0;
        held_byte_q     <= '0;
        pair_phase_q    <= '0;
        bytes_emitted_q <= '0;
        line_bad_q      <= 1'b0;
      end else begin
        char_index_q    <= char_index_d;
        saved_symbol_q  <= saved_symbol_d;
        held_byte_q     <= held_byte_d;
        pair_phase_q    <= pair_phase_d;
        bytes_emitted_q <= bytes_emitted_d;
        line_bad_q      <= line_bad_d;
      end
    end
  end

  assign char_index_d = idx_inc;
  assign line_bad_d   = bad_n;

endmodule

[rtl/core/jis7_line_decoder.sv]
// ----------------------------------------------------------------------------
// jis7_line_decoder: base-91 style text line decoder, one character a transfer
// Results of a character are registered and appear in the cycle after its input transfer.
// Throughput: one character per cycle while it causes at most one result and
// the output is ready; a character with several results holds the input until
// the single output stream has drained the result buffer to its last result.
// Reset: asynchronous, active low; clears line state, buffer, limit to 78.
// ----------------------------------------------------------------------------
module jis7_line_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: line_limit.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // line_end
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_count
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_result
);

  logic [7:0] line_limit_q;
  logic       s_xfer;
  logic       m_xfer;
  logic [1:0] num_q;
  jis7ld_pkg::res_t [jis7ld_pkg::MaxResults-1:0] res_q;
  jis7ld_pkg::bundle_t bundle;

  // Line limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= jis7ld_pkg::ResetLimit;
    end else if (cfg_we_i) begin
      line_limit_q <= cfg_wdata_i;
    end
  end

  // A new character is taken once the buffer is empty or drains this cycle.
  assign s_axis_tready = (num_q == 2'd0) || ((num_q == 2'd1) && m_axis_tready);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;

  jis7ld_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_xfer),
    .char_code_i  (s_axis_tdata),
    .line_end_i   (s_axis_tlast),
    .line_limit_i (line_limit_q),
    .bundle_o     (bundle)
  );

  // Result buffer count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 2'd0;
    end else if (s_xfer) begin
      num_q <= bundle.num;
    end else if (m_xfer) begin
      num_q <= num_q - 2'd1;
    end
  end

  // Result buffer payload; the head entry shifts out on each transfer.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      res_q <= bundle.res;
    end else if (m_xfer) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_axis_tvalid = num_q != 2'd0;
  assign m_axis_tdata  = {res_q[0].byte_count, res_q[0].data_byte};
  assign m_axis_tuser  = res_q[0].kind;
  assign m_axis_tlast  = res_q[0].last_result;

  // The last buffered result of a character carries the last flag.
  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_q != 2'd0) |-> res_q[num_q - 2'd1].last_result)
    else $error("final buffered result lacks last flag");

  // Only the final buffered result may carry the last flag.
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (num_q == 2'd1))
    else $error("last flag before the end of the buffered results");

  // A status result always closes its character.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != jis7ld_pkg::KindData)) |-> m_axis_tlast)
    else $error("status result not final");

endmodule
